// ===== rtl/core/pal_composite_line_generator_top_assert.svh =====
// Assertion macros for the PAL composite line generator.
`ifndef PAL_COMPOSITE_LINE_GENERATOR_TOP_ASSERT_SVH
`define PAL_COMPOSITE_LINE_GENERATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// a holds -> b holds in the same cycle
`define PCLG_ASSERT_IMPL(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("pclg check failed");

// a holds -> b holds in the next cycle
`define PCLG_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("pclg check failed");

`else

`define PCLG_ASSERT_IMPL(label, clk, rst_n, a, b)
`define PCLG_ASSERT_NEXT(label, clk, rst_n, a, b)

`endif

`endif

// ===== rtl/core/pclg_pkg.sv =====
// Types and constants of the PAL composite line generator.
package pclg_pkg;

	localparam int POS_W    = 11;
	localparam int LINE_W   = 10;
	localparam int DAC_W    = 16;
	localparam int ROW_W    = 9;
	localparam int COL_W    = 10;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 16;

	typedef logic [POS_W-1:0]     pos_t;
	typedef logic [LINE_W-1:0]    line_t;
	typedef logic [DAC_W-1:0]     dac_t;
	typedef logic [ROW_W-1:0]     row_t;
	typedef logic [COL_W-1:0]     col_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [CFG_DAT_W-1:0] cfg_dat_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINE_LENGTH   = 4'd0,
		REG_HSYNC_NORMAL  = 4'd1,
		REG_HSYNC_SHORT   = 4'd2,
		REG_HSYNC_LONG    = 4'd3,
		REG_BURST_OFFSET  = 4'd4,
		REG_ACTIVE_OFFSET = 4'd5,
		REG_SYNC_LEVEL    = 4'd6,
		REG_BLANK_LEVEL   = 4'd7
	} cfg_reg_t;

	localparam pos_t RST_LINE_LENGTH   = 11'd1132;
	localparam pos_t RST_HSYNC_NORMAL  = 11'd80;
	localparam pos_t RST_HSYNC_SHORT   = 11'd40;
	localparam pos_t RST_HSYNC_LONG    = 11'd484;
	localparam pos_t RST_BURST_OFFSET  = 11'd96;
	localparam pos_t RST_ACTIVE_OFFSET = 11'd184;
	localparam dac_t RST_SYNC_LEVEL    = 16'd0;
	localparam dac_t RST_BLANK_LEVEL   = 16'd18432;

	// burst amplitude = blank * BURST_MUL >> BURST_SHIFT (about 0.4707)
	localparam logic [7:0] BURST_MUL   = 8'd241;
	localparam int         BURST_SHIFT = 9;

	localparam line_t LAST_LINE     = 10'd624;
	localparam line_t REPAINT_LINE  = 10'd622;
	localparam line_t FIELD2_LINE   = 10'd313;
	localparam line_t ROW0_FIELD1   = 10'd23;
	localparam line_t ROW0_FIELD2   = 10'd335;

endpackage

// ===== rtl/core/pclg_in_if.sv =====
// Video sample input channel.
interface pclg_in_if;
	import pclg_pkg::*;

	logic valid;
	logic ready;
	dac_t video_sample;

	modport source (output valid, output video_sample, input ready);
	modport sink   (input valid, input video_sample, output ready);
endinterface

// ===== rtl/core/pclg_out_if.sv =====
// Composite sample output channel.
interface pclg_out_if;
	import pclg_pkg::*;

	logic valid;
	logic ready;
	dac_t dac_sample;
	logic pixel_used;
	row_t pixel_row;
	col_t pixel_column;
	logic odd_field;
	logic repaint_pulse;

	modport source (output valid, output dac_sample, output pixel_used, output pixel_row,
		output pixel_column, output odd_field, output repaint_pulse, input ready);
	modport sink   (input valid, input dac_sample, input pixel_used, input pixel_row,
		input pixel_column, input odd_field, input repaint_pulse, output ready);
endinterface

// ===== rtl/core/pclg_cfg_if.sv =====
// Configuration write channel.
interface pclg_cfg_if;
	import pclg_pkg::*;

	logic     valid;
	logic     ready;
	cfg_idx_t index;
	cfg_dat_t data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/pal_composite_line_generator_top.sv =====
// PAL composite line generator: sync, burst and picture overlay, one sample per item.
//
//   channel    dir  payload
//   video_in   in   video_sample
//   video_out  out  dac_sample, pixel_used, pixel_row, pixel_column, odd_field, repaint_pulse
//   cfg        in   index, data (write only, always ready)
//
// One item per cycle sustained while the output is not stalled; from accept to result an item
// passes through the input register (position snapshot) and the result register.
// Reset puts the counters at line 0, sample 0 and loads the default registers.
// A stalled result holds the result register; input ready drops only when both
// stages are full.
`include "pal_composite_line_generator_top_assert.svh"

module pal_composite_line_generator_top #(
	parameter int ACTIVE_SAMPLES = 920,
	parameter int BURST_SAMPLES  = 40
) (
	input  logic          clk,
	input  logic          arst_n,
	pclg_in_if.sink       video_in,
	pclg_out_if.source    video_out,
	pclg_cfg_if.sink      cfg
);
	import pclg_pkg::*;

	localparam logic [POS_W:0] ACT_LEN   = (POS_W+1)'(ACTIVE_SAMPLES);
	localparam logic [POS_W:0] BURST_LEN = (POS_W+1)'(BURST_SAMPLES);

	pos_t line_length_q, hsync_normal_q, hsync_short_q, hsync_long_q;
	pos_t burst_offset_q, active_offset_q;
	dac_t sync_level_q, blank_level_q;

	pos_t  pos_q;
	line_t line_q;

	logic  v_s1;
	dac_t  video_s1;
	pos_t  pos_s1;
	line_t line_s1;

	logic  v_s2;
	dac_t  dac_s2;
	logic  used_s2;
	row_t  row_s2;
	col_t  col_s2;
	logic  odd_s2;
	logic  repaint_s2;

	logic in_fire, adv;

	assign cfg.ready       = 1'b1;
	assign adv             = !v_s2 || video_out.ready;
	assign video_in.ready  = !v_s1 || adv;
	assign in_fire         = video_in.valid && video_in.ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q   <= RST_LINE_LENGTH;
			hsync_normal_q  <= RST_HSYNC_NORMAL;
			hsync_short_q   <= RST_HSYNC_SHORT;
			hsync_long_q    <= RST_HSYNC_LONG;
			burst_offset_q  <= RST_BURST_OFFSET;
			active_offset_q <= RST_ACTIVE_OFFSET;
			sync_level_q    <= RST_SYNC_LEVEL;
			blank_level_q   <= RST_BLANK_LEVEL;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_LINE_LENGTH:   line_length_q   <= cfg.data[POS_W-1:0];
				REG_HSYNC_NORMAL:  hsync_normal_q  <= cfg.data[POS_W-1:0];
				REG_HSYNC_SHORT:   hsync_short_q   <= cfg.data[POS_W-1:0];
				REG_HSYNC_LONG:    hsync_long_q    <= cfg.data[POS_W-1:0];
				REG_BURST_OFFSET:  burst_offset_q  <= cfg.data[POS_W-1:0];
				REG_ACTIVE_OFFSET: active_offset_q <= cfg.data[POS_W-1:0];
				REG_SYNC_LEVEL:    sync_level_q    <= cfg.data;
				REG_BLANK_LEVEL:   blank_level_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	// sample and line counters
	logic [POS_W:0] pos_inc;
	assign pos_inc = {1'b0, pos_q} + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			line_q <= '0;
		end else if (in_fire) begin
			if (pos_inc >= {1'b0, line_length_q}) begin
				pos_q  <= '0;
				line_q <= (line_q >= LAST_LINE) ? '0 : line_q + 1'b1;
			end else begin
				pos_q <= pos_inc[POS_W-1:0];
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (video_in.ready) begin
			v_s1 <= video_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			video_s1 <= video_in.video_sample;
			pos_s1   <= pos_q;
			line_s1  <= line_q;
		end
	end

	// line schedule
	pos_t  start_w, half_w;
	logic  has_burst, has_pic;
	line_t row_base;

	always_comb begin
		start_w   = hsync_short_q;
		half_w    = '0;
		has_burst = 1'b0;
		has_pic   = 1'b0;
		row_base  = ROW0_FIELD1;
		case (line_s1) inside
			[10'd0:10'd1]: begin
				start_w = hsync_long_q;
				half_w  = hsync_long_q;
			end
			10'd2: begin
				start_w = hsync_long_q;
				half_w  = hsync_short_q;
			end
			[10'd3:10'd4], [10'd310:10'd311], [10'd315:10'd316]: begin
				half_w = hsync_short_q;
			end
			[10'd5:10'd22], [10'd318:10'd334]: begin
				start_w   = hsync_normal_q;
				has_burst = 1'b1;
			end
			[10'd23:10'd309]: begin
				start_w   = hsync_normal_q;
				has_burst = 1'b1;
				has_pic   = 1'b1;
			end
			10'd312: begin
				half_w = hsync_long_q;
			end
			[10'd313:10'd314]: begin
				start_w = hsync_long_q;
				half_w  = hsync_long_q;
			end
			10'd317: begin
				start_w = hsync_short_q;
			end
			[10'd335:10'd621]: begin
				start_w   = hsync_normal_q;
				has_burst = 1'b1;
				has_pic   = 1'b1;
				row_base  = ROW0_FIELD2;
			end
			10'd622: begin
				start_w   = hsync_normal_q;
				has_burst = 1'b1;
				half_w    = hsync_short_q;
			end
			default: begin
				half_w = hsync_short_q;
			end
		endcase
	end

	// layers: blanking, start pulse, burst, picture, half-line pulse
	pos_t  half_pt, burst_diff, act_diff, half_diff;
	logic  in_burst, in_pic, in_half, burst_neg;
	logic [DAC_W+7:0] amp_prod;
	logic [DAC_W:0]   burst_hi;
	dac_t  amp, dac_c;
	line_t row_full;

	assign half_pt    = {1'b0, line_length_q[POS_W-1:3], 2'b00};
	assign burst_diff = pos_s1 - burst_offset_q;
	assign act_diff   = pos_s1 - active_offset_q;
	assign half_diff  = pos_s1 - half_pt;
	assign in_burst   = has_burst && (pos_s1 >= burst_offset_q)
		&& ({1'b0, burst_diff} < BURST_LEN);
	assign in_pic     = has_pic && (pos_s1 >= active_offset_q)
		&& ({1'b0, act_diff} < ACT_LEN);
	assign in_half    = (half_w != '0) && (pos_s1 >= half_pt) && (half_diff < half_w);
	assign burst_neg  = line_s1[0] ? burst_diff[1] : !(burst_diff[1] ^ burst_diff[0]);
	assign amp_prod   = blank_level_q * BURST_MUL;
	assign amp        = DAC_W'(amp_prod >> BURST_SHIFT);
	assign burst_hi   = {1'b0, blank_level_q} + {1'b0, amp};
	assign row_full   = line_s1 - row_base;

	always_comb begin
		dac_c = blank_level_q;
		if (pos_s1 < start_w)
			dac_c = sync_level_q;
		if (in_burst) begin
			if (burst_neg)
				dac_c = blank_level_q - amp;
			else
				dac_c = burst_hi[DAC_W] ? '1 : burst_hi[DAC_W-1:0];
		end
		if (in_pic)
			dac_c = video_s1;
		if (in_half)
			dac_c = sync_level_q;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			dac_s2     <= dac_c;
			used_s2    <= in_pic;
			row_s2     <= in_pic ? row_full[ROW_W-1:0] : '0;
			col_s2     <= in_pic ? act_diff[COL_W-1:0] : '0;
			odd_s2     <= line_s1 >= FIELD2_LINE;
			repaint_s2 <= (line_s1 == REPAINT_LINE) && (pos_s1 == '0);
		end
	end

	assign video_out.valid         = v_s2;
	assign video_out.dac_sample    = dac_s2;
	assign video_out.pixel_used    = used_s2;
	assign video_out.pixel_row     = row_s2;
	assign video_out.pixel_column  = col_s2;
	assign video_out.odd_field     = odd_s2;
	assign video_out.repaint_pulse = repaint_s2;

	`PCLG_ASSERT_IMPL(a_line_range, clk, arst_n, 1'b1, line_q <= LAST_LINE)
	`PCLG_ASSERT_IMPL(a_repaint_field, clk, arst_n, v_s2 && repaint_s2, odd_s2 && !used_s2)
	`PCLG_ASSERT_NEXT(a_result_follows, clk, arst_n, v_s1 && adv, v_s2)

endmodule
